// File: rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("implication check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("next-cycle check failed");

`endif

// File: rtl/lisw_pkg.sv
// shared types, codes and defaults of the lock interval wait block
// no dependencies
package lisw_pkg;
	localparam int MaxIntervalsDef = 64;
	localparam int TimeBitsDef     = 48;
	localparam int FieldBits       = 48;

	// operation codes on the item channel
	localparam logic [1:0] OP_ADD     = 2'd0;
	localparam logic [1:0] OP_COMPUTE = 2'd1;
	localparam logic [1:0] OP_CLEAR   = 2'd2;

	// status codes on the result channel
	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_OVF = 2'd1;
	localparam logic [1:0] ST_BAD = 2'd2;
	localparam logic [1:0] ST_SAT = 2'd3;

	// classified command kinds
	typedef enum logic [1:0] {
		CMD_ADD,
		CMD_COMPUTE,
		CMD_CLEAR,
		CMD_BAD
	} cmd_kind_t;

	typedef struct packed {
		logic      valid;
		cmd_kind_t kind;
	} cmd_ctl_t;
endpackage

// File: rtl/lisw_front.sv
// front end: accepts items, classifies them and queues commands
// depends on lisw_pkg
module lisw_front #(
	parameter int TIME_BITS = lisw_pkg::TimeBitsDef
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  logic [1:0]               operation,
	input  logic [47:0]              start_time,
	input  logic [47:0]              stop_time,
	output lisw_pkg::cmd_ctl_t       cmd,
	output logic [TIME_BITS-1:0]     cmd_start,
	output logic [TIME_BITS-1:0]     cmd_stop,
	input  logic                     cmd_pop
);
	import lisw_pkg::*;

	cmd_kind_t            kind_q  [2];
	logic [TIME_BITS-1:0] start_q [2];
	logic [TIME_BITS-1:0] stop_q  [2];
	logic                 wr_ptr_q, rd_ptr_q;
	logic [1:0]           cnt_q;

	logic [TIME_BITS-1:0] in_start, in_stop;
	cmd_kind_t            in_kind;
	logic                 in_keep, push, pop;

	// classify the incoming word
	always_comb begin
		in_start = TIME_BITS'(start_time);
		in_stop  = TIME_BITS'(stop_time);
		in_keep  = 1'b1;
		in_kind  = CMD_ADD;
		case (operation)
			OP_ADD:     in_kind = (in_stop < in_start) ? CMD_BAD : CMD_ADD;
			OP_COMPUTE: in_kind = CMD_COMPUTE;
			OP_CLEAR:   in_kind = CMD_CLEAR;
			default:    in_keep = 1'b0;
		endcase
	end

	assign item_stall = (cnt_q == 2'd2);
	assign push       = item_valid && !item_stall && in_keep;
	assign pop        = cmd_pop && (cnt_q != 2'd0);

	// two-entry command queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			kind_q[wr_ptr_q]  <= in_kind;
			start_q[wr_ptr_q] <= in_start;
			stop_q[wr_ptr_q]  <= in_stop;
		end
	end

	assign cmd.valid = (cnt_q != 2'd0);
	assign cmd.kind  = kind_q[rd_ptr_q];
	assign cmd_start = start_q[rd_ptr_q];
	assign cmd_stop  = stop_q[rd_ptr_q];
endmodule

// File: rtl/lisw_back.sv
// back end: sorted interval store, insertion and compute walk, result register
// depends on lisw_pkg
module lisw_back #(
	parameter int MAX_INTERVALS = lisw_pkg::MaxIntervalsDef,
	parameter int TIME_BITS     = lisw_pkg::TimeBitsDef
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lisw_pkg::cmd_ctl_t   cmd,
	input  logic [TIME_BITS-1:0] cmd_start,
	input  logic [TIME_BITS-1:0] cmd_stop,
	output logic                 cmd_pop,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [47:0]          wait_time,
	output logic [1:0]           status
);
	import lisw_pkg::*;

	localparam int TB = TIME_BITS;
	localparam int IW = $clog2(MAX_INTERVALS);
	localparam int CW = $clog2(MAX_INTERVALS + 1);
	localparam logic [CW-1:0] CntMax = CW'(MAX_INTERVALS);
	localparam logic [CW-1:0] CntOne = CW'(1);
	localparam logic [TB-1:0] WaitMax =
		(TB > FieldBits) ? TB'({FieldBits{1'b1}}) : {TB{1'b1}};

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_INS_PUT,
		S_CMP_FIRST,
		S_CMP_WALK,
		S_CMP_FIN
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  count_q;
	logic           ovf_q, bad_q;
	logic [TB-1:0]  max_stop_q, new_start_q, new_stop_q;
	logic [TB-1:0]  prev_q, omax_q;
	logic           sat_q;
	logic [IW-1:0]  j_q, idx_q;
	logic           out_valid_q;
	logic [47:0]    wait_q;
	logic [1:0]     status_q;

	logic [2*TB-1:0] mem_q [MAX_INTERVALS];
	logic [2*TB-1:0] rd_q;

	logic            wr_en, rd_en;
	logic [IW-1:0]   wr_addr, rd_addr;
	logic [2*TB-1:0] wr_data;

	logic [TB-1:0] rd_start, rd_stop, e_new, diff;
	logic [TB:0]   shift_sum;
	logic          do_shift, sat_now, ins_gt, idx_last;
	logic [1:0]    flag_status;

	assign rd_start = rd_q[2*TB-1:TB];
	assign rd_stop  = rd_q[TB-1:0];

	// overlap shift of the entry under the walk
	assign do_shift  = prev_q > rd_start;
	assign shift_sum = {1'b0, prev_q} + (TB+1)'(1) + {1'b0, rd_stop} - {1'b0, rd_start};
	assign sat_now   = do_shift && shift_sum[TB];
	assign e_new     = do_shift ? shift_sum[TB-1:0] : rd_stop;
	assign ins_gt    = rd_start > new_start_q;
	assign idx_last  = (CW'(idx_q) == count_q - CntOne);
	assign diff      = omax_q - max_stop_q;
	assign flag_status = bad_q ? ST_BAD : (ovf_q ? ST_OVF : ST_OK);

	// memory port control
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = {new_start_q, new_stop_q};
		rd_en   = 1'b0;
		rd_addr = '0;
		cmd_pop = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					case (cmd.kind)
						CMD_ADD: begin
							cmd_pop = 1'b1;
							if (count_q == '0) begin
								wr_en   = 1'b1;
								wr_data = {cmd_start, cmd_stop};
							end else if (count_q != CntMax) begin
								rd_en   = 1'b1;
								rd_addr = IW'(count_q - CntOne);
							end
						end
						CMD_COMPUTE: begin
							if (!out_valid_q) begin
								cmd_pop = 1'b1;
								rd_en   = (count_q > CntOne);
							end
						end
						default: cmd_pop = 1'b1;
					endcase
				end
			end
			S_INS: begin
				wr_en   = 1'b1;
				wr_addr = j_q + IW'(1);
				if (ins_gt) begin
					wr_data = rd_q;
					if (j_q != '0) begin
						rd_en   = 1'b1;
						rd_addr = j_q - IW'(1);
					end
				end
			end
			S_INS_PUT: wr_en = 1'b1;
			S_CMP_FIRST: begin
				rd_en   = 1'b1;
				rd_addr = IW'(1);
			end
			S_CMP_WALK: begin
				if (!sat_now && !idx_last) begin
					rd_en   = 1'b1;
					rd_addr = idx_q + IW'(1);
				end
			end
			default: ;
		endcase
	end

	// interval store, registered read
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem_q[rd_addr];
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			bad_q       <= 1'b0;
			max_stop_q  <= '0;
			out_valid_q <= 1'b0;
			sat_q       <= 1'b0;
		end else begin
			if (out_valid_q && !result_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						case (cmd.kind)
							CMD_ADD: begin
								if (count_q == CntMax) begin
									ovf_q <= 1'b1;
								end else begin
									if (cmd_stop > max_stop_q) max_stop_q <= cmd_stop;
									if (count_q == '0) begin
										count_q <= CntOne;
									end else begin
										new_start_q <= cmd_start;
										new_stop_q  <= cmd_stop;
										j_q         <= IW'(count_q - CntOne);
										state_q     <= S_INS;
									end
								end
							end
							CMD_COMPUTE: begin
								if (!out_valid_q) begin
									if (count_q > CntOne) begin
										state_q <= S_CMP_FIRST;
									end else begin
										out_valid_q <= 1'b1;
										wait_q      <= '0;
										status_q    <= flag_status;
									end
								end
							end
							CMD_CLEAR: begin
								count_q    <= '0;
								ovf_q      <= 1'b0;
								bad_q      <= 1'b0;
								max_stop_q <= '0;
							end
							default: bad_q <= 1'b1;
						endcase
					end
				end
				S_INS: begin
					if (ins_gt) begin
						if (j_q == '0) state_q <= S_INS_PUT;
						else j_q <= j_q - IW'(1);
					end else begin
						count_q <= count_q + CntOne;
						state_q <= S_IDLE;
					end
				end
				S_INS_PUT: begin
					count_q <= count_q + CntOne;
					state_q <= S_IDLE;
				end
				S_CMP_FIRST: begin
					prev_q  <= rd_stop;
					omax_q  <= rd_stop;
					sat_q   <= 1'b0;
					idx_q   <= IW'(1);
					state_q <= S_CMP_WALK;
				end
				S_CMP_WALK: begin
					if (sat_now) begin
						sat_q   <= 1'b1;
						state_q <= S_CMP_FIN;
					end else begin
						prev_q <= e_new;
						if (e_new > omax_q) omax_q <= e_new;
						if (idx_last) state_q <= S_CMP_FIN;
						else idx_q <= idx_q + IW'(1);
					end
				end
				S_CMP_FIN: begin
					out_valid_q <= 1'b1;
					if (sat_q || (diff > WaitMax)) begin
						wait_q   <= 48'(WaitMax);
						status_q <= ST_SAT;
					end else begin
						wait_q   <= 48'(diff);
						status_q <= flag_status;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign wait_time    = wait_q;
	assign status       = status_q;
endmodule

// File: rtl/lock_interval_serial_wait_core.sv
// top level of the lock interval wait block
// depends on lisw_pkg, lisw_front, lisw_back
//
// Items enter a two-word command queue and are carried out by a sequencer
// around an interval memory with one read and one write port, kept sorted by
// start (stable). An add to an empty or full store ends in S_IDLE; others walk
// S_INS, shifting each entry with a later start up one place, then S_INS_PUT
// if it goes first. A compute with n entries walks S_CMP_FIRST, S_CMP_WALK
// (one read per entry, fewer on saturation) and S_CMP_FIN; with n of 0 or 1
// it ends in S_IDLE, as do clear and bad intervals. A finished result waits
// in an output register while adds continue; the next compute waits until
// it is taken. No clearing pass after reset.
module lock_interval_serial_wait_core #(
	parameter int MAX_INTERVALS = lisw_pkg::MaxIntervalsDef,
	parameter int TIME_BITS     = lisw_pkg::TimeBitsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  operation,
	input  logic [47:0] start_time,
	input  logic [47:0] stop_time,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [47:0] wait_time,
	output logic [1:0]  status
);
	import lisw_pkg::*;

	cmd_ctl_t             cmd;
	logic [TIME_BITS-1:0] cmd_start, cmd_stop;
	logic                 cmd_pop;

	// classification and queue
	lisw_front #(.TIME_BITS(TIME_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.operation(operation), .start_time(start_time), .stop_time(stop_time),
		.cmd(cmd), .cmd_start(cmd_start), .cmd_stop(cmd_stop), .cmd_pop(cmd_pop)
	);

	// store and compute
	lisw_back #(.MAX_INTERVALS(MAX_INTERVALS), .TIME_BITS(TIME_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .cmd_start(cmd_start), .cmd_stop(cmd_stop), .cmd_pop(cmd_pop),
		.result_valid(result_valid), .result_stall(result_stall),
		.wait_time(wait_time), .status(status)
	);
endmodule

// File: rtl/lisw_checker.sv
// port-level checks of the lock interval wait block, bound to the top level
// depends on lisw_pkg and assert_macros.svh
`include "assert_macros.svh"
module lisw_checker #(
	parameter int TIME_BITS = lisw_pkg::TimeBitsDef
) (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_stall,
	input logic [47:0] wait_time,
	input logic [1:0]  status
);
	import lisw_pkg::*;

	localparam logic [47:0] SatWord =
		(TIME_BITS >= FieldBits) ? {FieldBits{1'b1}} : 48'((64'd1 << TIME_BITS) - 64'd1);

	// a stalled result holds
	`ASSERT_NEXT(a_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(wait_time) && $stable(status))
	// a saturated result carries the saturation word
	`ASSERT_IMPLY(a_sat, clk, arst_n, result_valid && (status == ST_SAT), wait_time == SatWord)
	// a taken result is never followed by another at once
	`ASSERT_NEXT(a_gap, clk, arst_n, result_valid && !result_stall, !result_valid)
endmodule

bind lock_interval_serial_wait_core lisw_checker #(.TIME_BITS(TIME_BITS)) u_lisw_checker (.*);

// File: verif/lock_interval_serial_wait_core_tb.sv
// testbench of the lock interval wait block: directed and random words
// checked against an in-bench model of the interval store and walk
// depends on lisw_pkg and lock_interval_serial_wait_core
module lock_interval_serial_wait_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lisw_pkg::*;

	localparam int          Depth      = MaxIntervalsDef;
	localparam logic [47:0] TickMax    = 48'hFFFF_FFFF_FFFF;
	localparam logic [1:0]  OP_UNUSED  = 2'd3;
	localparam int          CycleLimit = 2000000;

	typedef struct {
		logic [47:0] wait_time;
		logic [1:0]  status;
	} wait_result_t;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	logic [1:0]  operation;
	logic [47:0] start_time;
	logic [47:0] stop_time;
	logic        result_valid;
	logic        result_stall;
	logic [47:0] wait_time;
	logic [1:0]  status;

	// model state
	logic [47:0] held_start[$];
	logic [47:0] held_stop[$];
	bit          seen_overflow;
	bit          seen_bad;
	wait_result_t pending_waits[$];

	int  idle_pct;
	int  stall_pct;
	int  errors;
	int  cycles;

	lock_interval_serial_wait_core dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.operation(operation), .start_time(start_time), .stop_time(stop_time),
		.result_valid(result_valid), .result_stall(result_stall),
		.wait_time(wait_time), .status(status)
	);

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// wait time of the stored intervals after ordering them by start
	function automatic wait_result_t lock_wait(bit ovf, bit bad);
		wait_result_t r;
		logic [47:0] s[$];
		logic [47:0] e[$];
		logic [47:0] ks, ke, len, prev, top, max_stop;
		bit sat;
		int j;
		s = held_start;
		e = held_stop;
		sat = 0;
		r.wait_time = '0;
		if (s.size() > 1) begin
			max_stop = '0;
			foreach (e[i]) if (e[i] > max_stop) max_stop = e[i];
			// stable insertion sort by start
			for (int i = 1; i < s.size(); i++) begin
				ks = s[i];
				ke = e[i];
				j = i;
				while (j > 0 && s[j-1] > ks) begin
					s[j] = s[j-1];
					e[j] = e[j-1];
					j--;
				end
				s[j] = ks;
				e[j] = ke;
			end
			// shift overlapping intervals past their predecessor
			prev = e[0];
			top = prev;
			for (int i = 1; i < s.size() && !sat; i++) begin
				ks = s[i];
				ke = e[i];
				if (prev > ks) begin
					len = ke - ks;
					if (prev >= TickMax || len > TickMax - (prev + 48'd1)) begin
						sat = 1;
					end else begin
						ks = prev + 48'd1;
						ke = ks + len;
					end
				end
				if (ke > top) top = ke;
				prev = ke;
			end
			r.wait_time = sat ? TickMax : top - max_stop;
		end
		if (sat) r.status = ST_SAT;
		else if (bad) r.status = ST_BAD;
		else if (ovf) r.status = ST_OVF;
		else r.status = ST_OK;
		return r;
	endfunction

	// apply one accepted word to the model
	function automatic void model_word(logic [1:0] op, logic [47:0] s, logic [47:0] e);
		case (op)
			OP_ADD: begin
				if (e < s) seen_bad = 1;
				else if (held_start.size() >= Depth) seen_overflow = 1;
				else begin
					held_start.insert(held_start.size(), s);
					held_stop.insert(held_stop.size(), e);
				end
			end
			OP_COMPUTE: pending_waits.insert(pending_waits.size(),
				lock_wait(seen_overflow, seen_bad));
			OP_CLEAR: begin
				held_start.delete();
				held_stop.delete();
				seen_overflow = 0;
				seen_bad = 0;
			end
			default: ;
		endcase
	endfunction

	// send one word, waiting out stalls
	task automatic send_word(logic [1:0] op, logic [47:0] s, logic [47:0] e);
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		operation <= op;
		start_time <= s;
		stop_time <= e;
		do @(posedge clk); while (item_stall);
		model_word(op, s, e);
	endtask

	function automatic logic [47:0] any_tick();
		return 48'({$urandom, $urandom});
	endfunction

	// receiver stall
	always @(posedge clk) result_stall <= ($urandom_range(99) < stall_pct);

	// result check
	always @(posedge clk) begin
		wait_result_t x;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_waits.size() == 0) begin
				$error("result with no compute waiting: wait_time %0d status %0d",
					wait_time, status);
				errors++;
			end else begin
				x = pending_waits.pop_front();
				if (wait_time !== x.wait_time) begin
					$error("wait_time expected %0d actual %0d", x.wait_time, wait_time);
					errors++;
				end
				if (status !== x.status) begin
					$error("status expected %0d actual %0d", x.status, status);
					errors++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// extremes, flags, saturation, overflow and small stores
	task automatic test_directed();
		send_word(OP_COMPUTE, '0, '0);
		send_word(OP_ADD, 48'd10, 48'd20);
		send_word(OP_COMPUTE, '0, '0);
		send_word(OP_ADD, 48'd15, 48'd30);
		send_word(OP_ADD, 48'd10, 48'd12);
		send_word(OP_ADD, 48'd5, 48'd4);
		send_word(OP_UNUSED, TickMax, 48'd0);
		send_word(OP_COMPUTE, TickMax, TickMax);
		send_word(OP_CLEAR, '0, '0);
		send_word(OP_ADD, '0, TickMax);
		send_word(OP_ADD, 48'd1, TickMax);
		send_word(OP_COMPUTE, '0, '0);
		send_word(OP_CLEAR, TickMax, TickMax);
		send_word(OP_ADD, TickMax, TickMax);
		send_word(OP_ADD, TickMax, TickMax);
		send_word(OP_ADD, '0, '0);
		send_word(OP_COMPUTE, '0, '0);
		send_word(OP_CLEAR, '0, '0);
		// fill the store past its depth
		for (int i = 0; i < Depth + 2; i++) send_word(OP_ADD, 48'(i % 7), 48'(i % 7 + 3));
		send_word(OP_COMPUTE, '0, '0);
		send_word(OP_CLEAR, '0, '0);
	endtask

	// random add runs ending in a compute, with noise words between
	task automatic test_random(int words, int idle, int stall);
		logic [47:0] base, s, e;
		int k, sent;
		idle_pct = idle;
		stall_pct = stall;
		sent = 0;
		while (sent < words) begin
			k = ($urandom_range(19) == 0) ? $urandom_range(Depth + 4) : $urandom_range(8);
			base = ($urandom_range(3) == 0) ? any_tick() : 48'($urandom_range(1000));
			if ($urandom_range(1)) begin
				send_word(OP_CLEAR, any_tick(), any_tick());
				sent++;
			end
			for (int i = 0; i < k; i++) begin
				case ($urandom_range(9))
					0: begin
						s = any_tick();
						e = any_tick();
					end
					1: begin
						s = TickMax - 48'($urandom_range(50));
						e = s + 48'($urandom_range(int'(TickMax - s)));
					end
					default: begin
						s = base + 48'($urandom_range(40));
						e = s + 48'($urandom_range(30));
						if (e < s) e = TickMax;
					end
				endcase
				send_word(OP_ADD, s, e);
				sent++;
			end
			if ($urandom_range(9) == 0) begin
				send_word(OP_UNUSED, any_tick(), any_tick());
				sent++;
			end
			send_word(OP_COMPUTE, any_tick(), any_tick());
			sent++;
		end
	endtask

	initial begin
		item_valid = 1'b0;
		operation = OP_ADD;
		start_time = '0;
		stop_time = '0;
		result_stall = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		errors = 0;
		cycles = 0;
		seen_overflow = 0;
		seen_bad = 0;
		@(posedge arst_n);
		@(posedge clk);
		test_directed();
		test_random(375, 0, 0);
		test_random(375, 81, 0);
		test_random(375, 0, 81);
		test_random(375, 30, 30);
		item_valid <= 1'b0;
		while (pending_waits.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && pending_waits.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
